// ----- src/fwme_pkg.sv -----
// Package for the min-extract FIFO: payload structs, request and error codes,
// the per-cell command struct and default parameter values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fwme_pkg;

    localparam int DEFAULT_DEPTH       = 16;
    localparam int DEFAULT_VALUE_WIDTH = 32;

    localparam int REQ_WIDTH   = 3;
    localparam int FIELD_WIDTH = 32;
    localparam int COUNT_WIDTH = 5;
    localparam int ERR_WIDTH   = 2;

    localparam logic [REQ_WIDTH-1:0] REQ_APPEND       = 3'd0;
    localparam logic [REQ_WIDTH-1:0] REQ_REMOVE_FRONT = 3'd1;
    localparam logic [REQ_WIDTH-1:0] REQ_REMOVE_MIN   = 3'd2;
    localparam logic [REQ_WIDTH-1:0] REQ_CLEAR        = 3'd3;

    localparam logic [ERR_WIDTH-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_WIDTH-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_WIDTH-1:0] ERR_FULL  = 2'd2;

    typedef struct packed {
        logic [REQ_WIDTH-1:0]          req_type;
        logic signed [FIELD_WIDTH-1:0] new_value;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] removed_value;
        logic signed [FIELD_WIDTH-1:0] front_value;
        logic signed [FIELD_WIDTH-1:0] smallest_value;
        logic [COUNT_WIDTH-1:0]        entry_count;
        logic [ERR_WIDTH-1:0]          error_code;
    } t_out_item;

    // Broadcast to every cell for one cycle when a value is appended or removed.
    typedef struct packed {
        logic append;  // the cell at the given position loads the new value
        logic shift;   // cells at or after the given position load their right neighbor
    } t_cell_cmd;

endpackage

`default_nettype wire

// ----- src/fwme_cell.sv -----
// One storage cell of the min-extract FIFO chain, with its stage of the
// registered minimum search. Depends on fwme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fwme_cell #(
    parameter int DEPTH       = fwme_pkg::DEFAULT_DEPTH,
    parameter int VALUE_WIDTH = fwme_pkg::DEFAULT_VALUE_WIDTH,
    parameter int IDX         = 0,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire fwme_pkg::t_cell_cmd     i_cmd,
    input  wire [IW-1:0]                 i_pos,
    input  wire signed [VALUE_WIDTH-1:0] i_new_value,
    input  wire signed [VALUE_WIDTH-1:0] i_right_value,
    input  wire [CW-1:0]                 i_count,
    input  wire                          i_cand_found,
    input  wire signed [VALUE_WIDTH-1:0] i_cand_value,
    input  wire [IW-1:0]                 i_cand_idx,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic                         o_cand_found,
    output logic signed [VALUE_WIDTH-1:0] o_cand_value,
    output logic [IW-1:0]                o_cand_idx
);

    logic signed [VALUE_WIDTH-1:0] r_value;
    logic                          r_found;
    logic signed [VALUE_WIDTH-1:0] r_cval;
    logic [IW-1:0]                 r_cidx;
    logic                          w_occupied;
    logic                          w_take_own;

    assign w_occupied = (CW'(IDX) < i_count);
    // Strictly smaller only, so the earlier entry wins a tie.
    assign w_take_own = w_occupied && (!i_cand_found || (r_value < i_cand_value));

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && (i_pos == IW'(IDX))) begin
            r_value <= i_new_value;
        end else if (i_cmd.shift && (IW'(IDX) >= i_pos)) begin
            r_value <= i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= w_take_own || i_cand_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_own) begin
            r_cval <= r_value;
            r_cidx <= IW'(IDX);
        end else begin
            r_cval <= i_cand_value;
            r_cidx <= i_cand_idx;
        end
    end

    assign o_value      = r_value;
    assign o_cand_found = r_found;
    assign o_cand_value = r_cval;
    assign o_cand_idx   = r_cidx;

endmodule

`default_nettype wire

// ----- src/fifo_with_min_extract.sv -----
// Top level of the min-extract FIFO: request sequencer, cell chain and
// output register. Depends on fwme_pkg and fwme_cell.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Valid        Stall         Payload
// request   in         i_in_valid   o_in_stall    i_in_data  (t_in_item)
// result    out        o_out_valid  i_out_stall   o_out_data (t_out_item)
//
// Each request passes from its transfer to the next possible transfer through these steps: accept,
// update the cells, let the minimum ripple through the registered compare chain (one cell per
// cycle), and load the result register. Reset is synchronous and active low; it empties the
// store, while cell contents stay undefined until written. A stalled result holds in the output
// register; the next request is taken meanwhile and waits at its last step only if the register
// is still full and stalled.

module fifo_with_min_extract #(
    parameter int DEPTH       = fwme_pkg::DEFAULT_DEPTH,
    parameter int VALUE_WIDTH = fwme_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire fwme_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output fwme_pkg::t_out_item      o_out_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // One-hot sequencer states.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Accepted request.
    logic [fwme_pkg::REQ_WIDTH-1:0] r_req;
    logic signed [VALUE_WIDTH-1:0]  r_new_value;

    // Store bookkeeping and per-request results.
    logic [CW-1:0]                  r_count, n_count;
    logic [IW-1:0]                  r_scan_cnt, n_scan_cnt;
    logic [fwme_pkg::ERR_WIDTH-1:0] r_err, n_err;
    logic signed [VALUE_WIDTH-1:0]  r_removed, n_removed;

    // Earliest smallest entry from the last completed search. Every change
    // of the store is followed by a full search, so this always matches the
    // current contents when a new request executes.
    logic [IW-1:0]                  r_min_idx;
    logic signed [VALUE_WIDTH-1:0]  r_min_value;

    logic                           r_out_valid;
    fwme_pkg::t_out_item            r_out;

    // Cell chain wiring.
    fwme_pkg::t_cell_cmd            w_cmd;
    logic [IW-1:0]                  w_pos;
    logic signed [VALUE_WIDTH-1:0]  w_value    [DEPTH];
    logic                           w_found    [DEPTH];
    logic signed [VALUE_WIDTH-1:0]  w_cval     [DEPTH];
    logic [IW-1:0]                  w_cidx     [DEPTH];

    logic                           w_accept;
    logic                           w_load_out;
    logic                           w_empty;

    assign w_accept   = (r_state == S_IDLE) && i_in_valid;
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign w_empty    = (r_count == '0);

    // Next state, scan counter and the execute step: decide the cell command, the new fill count,
    // the removed value and the error code for the accepted request.
    always_comb begin
        w_cmd      = '0;
        w_pos      = '0;
        n_count    = r_count;
        n_err      = r_err;
        n_removed  = r_removed;
        n_state    = r_state;
        n_scan_cnt = r_scan_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_err      = fwme_pkg::ERR_OK;
                n_removed  = '0;
                n_scan_cnt = '0;
                n_state    = S_SCAN;
                case (r_req)
                    fwme_pkg::REQ_APPEND: begin
                        if (r_count == CW'(DEPTH)) begin
                            n_err = fwme_pkg::ERR_FULL;
                        end else begin
                            w_cmd.append = 1'b1;
                            w_pos        = r_count[IW-1:0];
                            n_count      = r_count + CW'(1);
                        end
                    end
                    fwme_pkg::REQ_REMOVE_FRONT: begin
                        if (w_empty) begin
                            n_err = fwme_pkg::ERR_EMPTY;
                        end else begin
                            w_cmd.shift = 1'b1;
                            w_pos       = '0;
                            n_removed   = w_value[0];
                            n_count     = r_count - CW'(1);
                        end
                    end
                    fwme_pkg::REQ_REMOVE_MIN: begin
                        if (w_empty) begin
                            n_err = fwme_pkg::ERR_EMPTY;
                        end else begin
                            w_cmd.shift = 1'b1;
                            w_pos       = r_min_idx;
                            n_removed   = r_min_value;
                            n_count     = r_count - CW'(1);
                        end
                    end
                    fwme_pkg::REQ_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        // The unused request codes leave the store as it is.
                    end
                endcase
            end
            S_SCAN: begin
                if (r_scan_cnt == IW'(DEPTH - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_scan_cnt = r_scan_cnt + IW'(1);
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_cnt <= n_scan_cnt;
        r_err      <= n_err;
        r_removed  <= n_removed;
        if (w_accept) begin
            r_req       <= i_in_data.req_type;
            r_new_value <= VALUE_WIDTH'(i_in_data.new_value);
        end
        // The last cell holds the search result for the whole store here.
        if (r_state == S_DONE) begin
            r_min_idx   <= w_cidx[DEPTH-1];
            r_min_value <= w_cval[DEPTH-1];
        end
        if (w_load_out) begin
            r_out.removed_value  <= fwme_pkg::FIELD_WIDTH'(r_removed);
            r_out.front_value    <= w_empty ? '0 : fwme_pkg::FIELD_WIDTH'(w_value[0]);
            r_out.smallest_value <= w_empty ? '0 :
                                    fwme_pkg::FIELD_WIDTH'(w_cval[DEPTH-1]);
            r_out.entry_count    <= fwme_pkg::COUNT_WIDTH'(r_count);
            r_out.error_code     <= r_err;
        end
    end

    // The chain: cell g shifts in from cell g+1 on removal, and passes its
    // running minimum to cell g+1 every cycle.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VALUE_WIDTH-1:0] w_right;
        logic                          w_in_found;
        logic signed [VALUE_WIDTH-1:0] w_in_value;
        logic [IW-1:0]                 w_in_idx;

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_value[g];
        end else begin : g_mid
            assign w_right = w_value[g+1];
        end

        if (g == 0) begin : g_head
            assign w_in_found = 1'b0;
            assign w_in_value = '0;
            assign w_in_idx   = '0;
        end else begin : g_body
            assign w_in_found = w_found[g-1];
            assign w_in_value = w_cval[g-1];
            assign w_in_idx   = w_cidx[g-1];
        end

        fwme_cell #(
            .DEPTH       (DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX         (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_pos         (w_pos),
            .i_new_value   (r_new_value),
            .i_right_value (w_right),
            .i_count       (r_count),
            .i_cand_found  (w_in_found),
            .i_cand_value  (w_in_value),
            .i_cand_idx    (w_in_idx),
            .o_value       (w_value[g]),
            .o_cand_found  (w_found[g]),
            .o_cand_value  (w_cval[g]),
            .o_cand_idx    (w_cidx[g])
        );
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // A full-store error is only reported when the store is full.
    a_full_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error_code == fwme_pkg::ERR_FULL) |->
        (o_out_data.entry_count == fwme_pkg::COUNT_WIDTH'(DEPTH)))
        else $error("full error reported with a store that is not full");

    // An empty-store error leaves nothing removed and an empty store.
    a_empty_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error_code == fwme_pkg::ERR_EMPTY) |->
        (o_out_data.entry_count == '0 && o_out_data.removed_value == '0))
        else $error("empty error reported with entries present or a value removed");

    // Every store update is followed by a search.
    a_exec_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_SCAN))
        else $error("store update not followed by a search");

    // When the search ends on a non-empty store, it has found an entry.
    a_search_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_count != '0) |-> w_found[DEPTH-1])
        else $error("search finished without a candidate");
`endif

endmodule

`default_nettype wire
